// ===== hdl/polyphase_iq_resampler_125_128_defines.svh =====
// Assertion macros for the 125/128 polyphase I/Q resampler.
`ifndef POLYPHASE_IQ_RESAMPLER_125_128_DEFINES_SVH
`define POLYPHASE_IQ_RESAMPLER_125_128_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PIR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pir: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define PIR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pir: next-cycle check failed");

`endif

// ===== hdl/pir_pkg.sv =====
// Package: constants, payload types and coefficient table of the polyphase I/Q resampler.
package pir_pkg;

  localparam int TAP_COUNT   = 9;
  localparam int UP_FACTOR   = 125;
  localparam int DOWN_FACTOR = 128;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + $clog2(TAP_COUNT) + 1;

  localparam int GROUP_SIZE  = 3;
  localparam int GROUP_COUNT = (TAP_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam int PHASE_MAX = (UP_FACTOR > DOWN_FACTOR) ? UP_FACTOR : DOWN_FACTOR;
  localparam int PHASE_W   = (PHASE_MAX > 1) ? $clog2(PHASE_MAX) : 1;
  localparam int PSUM_W    = $clog2(UP_FACTOR + DOWN_FACTOR) + 1;

  localparam int ROM_SIZE  = TAP_COUNT * UP_FACTOR;
  localparam int ROM_IDX_W = $clog2(ROM_SIZE);

  localparam int ROUND_BIAS = 32'h7fff;
  localparam int OUT_SHIFT  = 15;
  localparam int SAT_MAX    = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAT_MIN    = -(2 ** (SAMPLE_W - 1));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       skip_output;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_i;
    logic signed [SAMPLE_W-1:0] out_q;
  } out_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_q;
  } lane_out_t;

  typedef logic [ROM_SIZE-1:0][COEF_W-1:0] coef_rom_t;

  typedef logic [63:0] u64_t;

  typedef struct packed {
    u64_t q;
    u64_t r;
  } divres_t;

  typedef struct packed {
    logic neg;
    u64_t mag;
  } sinc_t;

  localparam int   FRAC_BITS = 48;
  localparam u64_t ONE_Q     = 64'h0001_0000_0000_0000;
  localparam u64_t PI_Q48    = 64'h0003_243F_6A88_85A3;

  function automatic divres_t udivmod(input u64_t num, input u64_t den);
    divres_t res;
    u64_t    r;
    u64_t    q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    res.q = q;
    res.r = r;
    return res;
  endfunction

  function automatic u64_t mul_q(input u64_t a, input u64_t b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[111:48];
  endfunction

  function automatic u64_t div_frac(input u64_t num, input u64_t den);
    divres_t d;
    u64_t    q;
    u64_t    r;
    d = udivmod(num, den);
    q = d.q;
    r = d.r;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic u64_t bessel_q(input u64_t hq);
    u64_t    sum;
    u64_t    term;
    logic    done;
    divres_t d;
    sum  = ONE_Q;
    term = ONE_Q;
    done = 1'b0;
    for (int k = 1; k < 50; k++) begin
      if (!done) begin
        d    = udivmod(mul_q(term, hq), u64_t'(k * k));
        term = d.q;
        if (term == '0) begin
          done = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  function automatic u64_t sin_q(input u64_t x);
    u64_t    x2;
    u64_t    term;
    u64_t    pos;
    u64_t    neg;
    divres_t d;
    x2   = mul_q(x, x);
    term = x;
    pos  = x;
    neg  = '0;
    for (int n = 1; n <= 15; n++) begin
      d    = udivmod(mul_q(term, x2), u64_t'((2 * n) * (2 * n + 1)));
      term = d.q;
      if (n[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : '0;
  endfunction

  function automatic sinc_t sinc_mag(input u64_t at);
    sinc_t   res;
    u64_t    half;
    u64_t    m;
    divres_t d;
    half    = u64_t'(10 * UP_FACTOR);
    res.neg = 1'b0;
    if (at == '0) begin
      d       = udivmod(PI_Q48 * 64'd8, half);
      res.mag = d.q;
    end else begin
      d = udivmod(at * 64'd8, half << 1);
      m = d.r;
      if (m >= half) begin
        m       = m - half;
        res.neg = 1'b1;
      end
      if (m > (half >> 1)) begin
        m = half - m;
      end
      d       = udivmod(PI_Q48 * m, half);
      d       = udivmod(sin_q(d.q), at);
      res.mag = d.q;
    end
    return res;
  endfunction

  function automatic coef_rom_t build_rom();
    coef_rom_t rom;
    longint    design_w [ROM_SIZE];
    u64_t      n1;
    u64_t      den;
    u64_t      at;
    u64_t      ua;
    u64_t      win;
    u64_t      mag;
    u64_t      num;
    u64_t      den2;
    u64_t      qv;
    longint    center;
    longint    t;
    longint    a;
    longint    sum;
    longint    w;
    sinc_t     sm;
    divres_t   d;
    int        k;
    int        idx;
    rom    = '0;
    n1     = u64_t'(ROM_SIZE - 1);
    den    = n1 * n1;
    center = longint'(ROM_SIZE / 2);
    for (int kb = 0; kb < ROM_SIZE; kb += 32) begin
      for (int ko = 0; ko < 32; ko++) begin
        k = kb + ko;
        if (k < ROM_SIZE) begin
          t   = longint'(k) - center;
          a   = 2 * longint'(k) - longint'(n1);
          at  = u64_t'((t < 0) ? -t : t);
          ua  = u64_t'((a < 0) ? -a : a);
          win = bessel_q(div_frac(64'd16 * (den - ua * ua), den));
          sm  = sinc_mag(at);
          mag = mul_q(sm.mag, win);
          mag = (mag + 64'd2048) >> 12;
          design_w[k] = sm.neg ? -longint'(mag) : longint'(mag);
        end
      end
    end
    for (int p = 0; p < UP_FACTOR; p++) begin
      sum = 0;
      for (int tap = 0; tap < TAP_COUNT; tap++) begin
        sum = sum + design_w[tap * UP_FACTOR + p];
      end
      for (int tap = 0; tap < TAP_COUNT; tap++) begin
        idx = tap * UP_FACTOR + p;
        w   = design_w[idx];
        if (sum <= 0) begin
          rom[idx] = '0;
        end else begin
          den2 = u64_t'(sum);
          num  = 64'd32767 * u64_t'((w < 0) ? -w : w);
          d    = udivmod(num, den2);
          qv   = d.q;
          if ((d.r << 1) >= den2) begin
            qv = qv + 64'd1;
          end
          if (qv > 64'd32767) begin
            qv = 64'd32767;
          end
          rom[idx] = (w < 0) ? COEF_W'(-qv) : COEF_W'(qv);
        end
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

endpackage

// ===== hdl/pir_lane.sv =====
// One tap lane: coefficient register and I/Q multipliers with registered products.
module pir_lane (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic signed [pir_pkg::COEF_W-1:0]    coef_i,
  input  logic                                 advance_i,
  input  logic signed [pir_pkg::SAMPLE_W-1:0]  samp_i_i,
  input  logic signed [pir_pkg::SAMPLE_W-1:0]  samp_q_i,
  output pir_pkg::lane_out_t                   prod_o
);
  import pir_pkg::*;

  logic signed [COEF_W-1:0] coef_q;
  lane_out_t                prod_d;
  lane_out_t                prod_q;

  always_comb begin
    prod_d.prod_i = samp_i_i * coef_q;
    prod_d.prod_q = samp_q_i * coef_q;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      coef_q <= coef_i;
    end
    if (advance_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/pir_merge.sv =====
// Merge stage: grouped lane sums, rounding bias, floor shift and saturation.
module pir_merge (
  input  logic               clk_i,
  input  logic               advance_i,
  input  pir_pkg::lane_out_t prod_i [pir_pkg::TAP_COUNT],
  output pir_pkg::out_item_t result_o
);
  import pir_pkg::*;

  logic signed [ACC_W-1:0] grp_i_d [GROUP_COUNT];
  logic signed [ACC_W-1:0] grp_q_d [GROUP_COUNT];
  logic signed [ACC_W-1:0] grp_i_q [GROUP_COUNT];
  logic signed [ACC_W-1:0] grp_q_q [GROUP_COUNT];
  logic signed [ACC_W-1:0] acc_i;
  logic signed [ACC_W-1:0] acc_q;
  out_item_t               result_d;
  out_item_t               result_q;

  function automatic logic signed [SAMPLE_W-1:0] sat_shift(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v >>> OUT_SHIFT;
    if (s > ACC_W'(SAT_MAX)) begin
      return SAMPLE_W'(SAT_MAX);
    end else if (s < ACC_W'(SAT_MIN)) begin
      return SAMPLE_W'(SAT_MIN);
    end
    return SAMPLE_W'(s);
  endfunction

  always_comb begin
    for (int g = 0; g < GROUP_COUNT; g++) begin
      grp_i_d[g] = '0;
      grp_q_d[g] = '0;
      for (int m = 0; m < GROUP_SIZE; m++) begin
        if (g * GROUP_SIZE + m < TAP_COUNT) begin
          grp_i_d[g] = grp_i_d[g] + ACC_W'(prod_i[g * GROUP_SIZE + m].prod_i);
          grp_q_d[g] = grp_q_d[g] + ACC_W'(prod_i[g * GROUP_SIZE + m].prod_q);
        end
      end
    end
  end

  always_comb begin
    acc_i = ACC_W'(ROUND_BIAS);
    acc_q = ACC_W'(ROUND_BIAS);
    for (int g = 0; g < GROUP_COUNT; g++) begin
      acc_i = acc_i + grp_i_q[g];
      acc_q = acc_q + grp_q_q[g];
    end
    result_d.out_i = sat_shift(acc_i);
    result_d.out_q = sat_shift(acc_q);
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      grp_i_q  <= grp_i_d;
      grp_q_q  <= grp_q_d;
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ===== hdl/polyphase_iq_resampler_125_128.sv =====
// Top level: delay lines, phase control, tap lanes, merge stage and output handshake.
// An accepted item moves through the delay line, product, group sum and result registers.
// Throughput: one item per cycle; nine lanes multiply I and Q for all taps at once,
// then a two-level adder tree merges them. A stalled output holds the whole pipeline.
// Reset clears the delay lines, the phase counter and all stage valid flags.
// The coefficient table is constant logic; no clearing pass after reset.
`include "polyphase_iq_resampler_125_128_defines.svh"

module polyphase_iq_resampler_125_128 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pir_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pir_pkg::out_item_t out_item_o
);
  import pir_pkg::*;

  logic                       adv;
  logic                       in_xfer;
  logic signed [SAMPLE_W-1:0] line_i_q [TAP_COUNT];
  logic signed [SAMPLE_W-1:0] line_q_q [TAP_COUNT];
  logic        [PHASE_W-1:0]  phase_q;
  logic        [PHASE_W-1:0]  phase_d;
  logic        [PSUM_W-1:0]   phase_sum;
  logic                       phase_lt;
  logic signed [COEF_W-1:0]   lane_coef [TAP_COUNT];
  lane_out_t                  lane_prod [TAP_COUNT];
  logic                       s1_valid_d;
  logic                       s1_valid_q;
  logic                       s2_valid_q;
  logic                       s3_valid_q;
  logic                       out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_xfer    = in_valid_i && adv;

  always_comb begin
    phase_lt  = PSUM_W'(phase_q) < PSUM_W'(UP_FACTOR);
    phase_sum = PSUM_W'(phase_q) + (phase_lt ? PSUM_W'(DOWN_FACTOR) : '0);
    if (phase_sum >= PSUM_W'(UP_FACTOR)) begin
      phase_d = PHASE_W'(phase_sum - PSUM_W'(UP_FACTOR));
    end else begin
      phase_d = PHASE_W'(phase_sum);
    end
    s1_valid_d = in_xfer && phase_lt && !in_item_i.skip_output;
  end

  always_comb begin
    for (int k = 0; k < TAP_COUNT; k++) begin
      if (phase_lt) begin
        lane_coef[k] = $signed(COEF_ROM[ROM_IDX_W'(k * UP_FACTOR) + ROM_IDX_W'(phase_q)]);
      end else begin
        lane_coef[k] = $signed(COEF_ROM[ROM_IDX_W'(k * UP_FACTOR)]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
        line_i_q[k] <= '0;
        line_q_q[k] <= '0;
      end
    end else if (in_xfer) begin
      phase_q     <= phase_d;
      line_i_q[0] <= in_item_i.sample_i;
      line_q_q[0] <= in_item_i.sample_q;
      for (int k = 1; k < TAP_COUNT; k++) begin
        line_i_q[k] <= line_i_q[k-1];
        line_q_q[k] <= line_q_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_lane
    pir_lane u_lane (
      .clk_i     (clk_i),
      .load_i    (in_xfer),
      .coef_i    (lane_coef[k]),
      .advance_i (adv),
      .samp_i_i  (line_i_q[k]),
      .samp_q_i  (line_q_q[k]),
      .prod_o    (lane_prod[k])
    );
  end

  pir_merge u_merge (
    .clk_i     (clk_i),
    .advance_i (adv),
    .prod_i    (lane_prod),
    .result_o  (out_item_o)
  );

  assign out_valid_o = out_valid_q;

  `PIR_ASSERT_NOW(a_phase_range, 1'b1, PSUM_W'(phase_q) < PSUM_W'(PHASE_MAX))
  `PIR_ASSERT_NEXT(a_stall_holds_phase, in_valid_i && !in_ready_o, $stable(phase_q))
  `PIR_ASSERT_NEXT(a_s1_needs_xfer, adv && !in_xfer, !s1_valid_q)
  `PIR_ASSERT_NOW(a_out_from_s3, $rose(out_valid_q), $past(s3_valid_q))

endmodule

// ===== test/iq_resample_check.sv =====
// Checker for the 125/128 I/Q resampler: watches both channels, predicts and compares.
module iq_resample_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  pir_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  pir_pkg::out_item_t out_item_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam int TAPS      = 9;
  localparam int PHASES    = 125;
  localparam int STRIDE    = 128;
  localparam int PROTO_LEN = TAPS * PHASES;
  localparam int MAX_SHOWN = 40;

  typedef bit [63:0] q48_t;

  localparam q48_t Q48_ONE = 64'h0001_0000_0000_0000;
  localparam q48_t Q48_PI  = 64'h0003_243F_6A88_85A3;

  int                 coef_tbl [PROTO_LEN];
  shortint            hist_i [TAPS];
  shortint            hist_q [TAPS];
  int                 phase_acc;
  pir_pkg::out_item_t pending_outputs [$];
  pir_pkg::out_item_t want;
  int                 fails;
  int                 checked;

  function automatic q48_t qmul(input q48_t a, input q48_t b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[111:48];
  endfunction

  function automatic q48_t frac_div(input q48_t num, input q48_t den);
    q48_t q;
    q48_t r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < 48; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r    = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic q48_t i0_series(input q48_t hq);
    q48_t acc_sum;
    q48_t term;
    acc_sum = Q48_ONE;
    term    = Q48_ONE;
    for (int k = 1; k < 50 && term != 0; k++) begin
      term    = qmul(term, hq) / q48_t'(k * k);
      acc_sum = acc_sum + term;
    end
    return acc_sum;
  endfunction

  function automatic q48_t sine_q48(input q48_t x);
    q48_t x2;
    q48_t term;
    q48_t pos;
    q48_t neg;
    x2   = qmul(x, x);
    term = x;
    pos  = x;
    neg  = 0;
    for (int n = 1; n <= 15; n++) begin
      term = qmul(term, x2) / q48_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic q48_t sinc_abs(input q48_t at, output bit negative);
    q48_t half;
    q48_t m;
    q48_t res;
    half     = q48_t'(10 * PHASES);
    negative = 1'b0;
    if (at == 0) begin
      res = Q48_PI * 64'd8 / half;
    end else begin
      m = (at * 64'd8) % (half * 64'd2);
      if (m >= half) begin
        m        = m - half;
        negative = 1'b1;
      end
      if (m > half / 64'd2) begin
        m = half - m;
      end
      res = sine_q48(Q48_PI * m / half) / at;
    end
    return res;
  endfunction

  function automatic shortint filter_phase(input bit use_q, input int ph);
    longint acc;
    acc = 64'sh7fff;
    for (int k = 0; k < TAPS; k++) begin
      acc += longint'(use_q ? hist_q[k] : hist_i[k]) * longint'(coef_tbl[k * PHASES + ph]);
    end
    acc = acc >>> 15;
    if (acc > 32767) begin
      acc = 32767;
    end else if (acc < -32768) begin
      acc = -32768;
    end
    return shortint'(acc);
  endfunction

  initial begin : build_coefs
    longint proto [PROTO_LEN];
    longint t;
    longint a;
    longint w;
    longint total;
    q48_t   den;
    q48_t   at;
    q48_t   ua;
    q48_t   win;
    q48_t   mag;
    q48_t   num;
    q48_t   qv;
    q48_t   rem;
    bit     neg;
    den = q48_t'(PROTO_LEN - 1) * q48_t'(PROTO_LEN - 1);
    for (int k = 0; k < PROTO_LEN; k++) begin
      t   = longint'(k) - longint'(PROTO_LEN / 2);
      a   = 2 * longint'(k) - longint'(PROTO_LEN - 1);
      at  = q48_t'((t < 0) ? -t : t);
      ua  = q48_t'((a < 0) ? -a : a);
      win = i0_series(frac_div(64'd16 * (den - ua * ua), den));
      mag = sinc_abs(at, neg);
      mag = qmul(mag, win);
      mag = (mag + 64'd2048) >> 12;
      proto[k] = neg ? -longint'(mag) : longint'(mag);
    end
    for (int p = 0; p < PHASES; p++) begin
      total = 0;
      for (int tap = 0; tap < TAPS; tap++) begin
        total += proto[tap * PHASES + p];
      end
      for (int tap = 0; tap < TAPS; tap++) begin
        w = proto[tap * PHASES + p];
        if (total <= 0) begin
          coef_tbl[tap * PHASES + p] = 0;
        end else begin
          num = 64'd32767 * q48_t'((w < 0) ? -w : w);
          qv  = num / q48_t'(total);
          rem = num % q48_t'(total);
          if ((rem << 1) >= q48_t'(total)) begin
            qv = qv + 64'd1;
          end
          if (qv > 64'd32767) begin
            qv = 64'd32767;
          end
          coef_tbl[tap * PHASES + p] = (w < 0) ? -int'(qv) : int'(qv);
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        hist_i[k] = 0;
        hist_q[k] = 0;
      end
      phase_acc = 0;
      pending_outputs.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (pending_outputs.size() == 0) begin
          fails++;
          if (fails <= MAX_SHOWN) begin
            $display("%0t: output transfer with nothing expected: expected none, actual %0d/%0d",
                     $time, out_item_i.out_i, out_item_i.out_q);
          end
        end else begin
          want = pending_outputs.pop_front();
          if (out_item_i.out_i !== want.out_i) begin
            fails++;
            if (fails <= MAX_SHOWN) begin
              $display("%0t: out_i mismatch: expected %0d, actual %0d",
                       $time, want.out_i, out_item_i.out_i);
            end
          end
          if (out_item_i.out_q !== want.out_q) begin
            fails++;
            if (fails <= MAX_SHOWN) begin
              $display("%0t: out_q mismatch: expected %0d, actual %0d",
                       $time, want.out_q, out_item_i.out_q);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        for (int k = TAPS - 1; k > 0; k--) begin
          hist_i[k] = hist_i[k-1];
          hist_q[k] = hist_q[k-1];
        end
        hist_i[0] = in_item_i.sample_i;
        hist_q[0] = in_item_i.sample_q;
        if (phase_acc < PHASES) begin
          if (!in_item_i.skip_output) begin
            want.out_i = filter_phase(1'b0, phase_acc);
            want.out_q = filter_phase(1'b1, phase_acc);
            pending_outputs.push_back(want);
          end
          phase_acc += STRIDE;
        end
        if (phase_acc >= PHASES) begin
          phase_acc -= PHASES;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= pending_outputs.size();
    checked_o    <= checked;
  end

endmodule

// ===== test/testbench.sv =====
// Top of the resampler test: clock, reset, handshake stimulus and the final verdict.
module testbench;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  pir_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  pir_pkg::out_item_t out_item;

  int send_idle = 0;
  int recv_idle = 0;
  int sent      = 0;
  int skipped   = 0;
  int cycles    = 0;
  int fail_count;
  int pending;
  int checked;

  polyphase_iq_resampler_125_128 u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  iq_resample_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic pir_pkg::in_item_t make_item(input logic signed [15:0] si,
                                                  input logic signed [15:0] sq,
                                                  input logic skip);
    pir_pkg::in_item_t it;
    it.sample_i    = si;
    it.sample_q    = sq;
    it.skip_output = skip;
    return it;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    logic signed [15:0] v;
    case ($urandom_range(9))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2: v = 16'(int'($urandom_range(255)) - 128);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_item(input pir_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready);
    sent++;
    if (it.skip_output) begin
      skipped++;
    end
  endtask

  // hold off the sender until every predicted output has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic random_run(input int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(39) == 0) begin
        repeat (12) begin
          send_item(make_item($urandom_range(1) ? 16'sh7fff : 16'sh8000,
                              $urandom_range(1) ? 16'sh7fff : 16'sh8000, 1'b0));
          n++;
        end
      end else begin
        send_item(make_item(pick_sample(), pick_sample(), $urandom_range(99) < 12));
        n++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 28;
    recv_idle = 85;
    repeat (4) send_item(make_item(16'sd0, 16'sd0, 1'b0));
    repeat (9) send_item(make_item(16'sh7fff, 16'sh8000, 1'b0));
    for (int k = 0; k < 9; k++) begin
      send_item(make_item(k[0] ? 16'sh8000 : 16'sh7fff, k[0] ? 16'sh7fff : 16'sh8000, 1'b0));
    end
    send_item(make_item(16'sh1234, -16'sd1, 1'b1));
    send_item(make_item(-16'sd1, 16'sd1, 1'b1));
    send_item(make_item(16'sd1, -16'sd1, 1'b0));
    drain();

    random_run(500);
    drain();

    send_idle = 85;
    recv_idle = 28;
    random_run(500);
    drain();

    send_idle = 0;
    recv_idle = 0;
    random_run(550);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d input transfers (%0d with skip set) and %0d output transfers,",
             sent, skipped, checked);
    $display("with sender/receiver idle at 28/85, 85/28 and 0/0 percent and full drains.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
